### design/sui_pkg.sv
// Shared types and codes for the set union / intersection / difference core.
// No dependencies; imported by the channel interfaces and every module.
`timescale 1ns / 1ps
`default_nettype none

package sui_pkg;

  localparam int VAL_W  = 32;
  localparam int KIND_W = 2;
  localparam int MODE_W = 2;

  // Cap on the number of results that one finish request produces.
  localparam int MAX_RESULTS = 32;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);

  // Input kind codes.
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  // op_mode codes.
  localparam logic [MODE_W-1:0] MODE_UNION = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INTER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PROBE,
    OP_FINISH
  } cmd_op_t;

  // Classified request handed from the front end to the engine.
  typedef struct packed {
    cmd_op_t            op;
    logic               want_hit;   // probe emits when found in reference set
    logic               want_miss;  // probe emits when not found
    logic               fin_union;  // finish flushes unemitted reference values
    logic [VAL_W-1:0]   value;
  } cmd_t;

endpackage

`default_nettype wire

### design/sui_if.sv
// Valid/ready channel interfaces: input requests, results and the op_mode write port.
// Depends on sui_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sui_in_if import sui_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sui_out_if import sui_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  result_value;
  logic                     has_value;
  logic                     last;
  logic                     overflow_seen;

  modport source (output valid, output result_value, output has_value, output last,
                  output overflow_seen, input ready);
  modport sink   (input valid, input result_value, input has_value, input last,
                  input overflow_seen, output ready);
endinterface

interface sui_cfg_if import sui_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  op_mode;

  modport source (output valid, output op_mode, input ready);
  modport sink   (input valid, input op_mode, output ready);
endinterface

`default_nettype wire

### design/sui_front.sv
// Front end: holds op_mode, accepts requests and classifies them into engine commands.
// Depends on sui_pkg and sui_if.
`timescale 1ns / 1ps
`default_nettype none

module sui_front import sui_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sui_in_if.sink      in_chan,
  sui_cfg_if.sink     cfg_chan,
  output logic        push_valid,
  input  wire logic   push_ready,
  output cmd_t        push_cmd
);

  logic [MODE_W-1:0] op_mode_r;
  logic              keep;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= MODE_UNION;
    end else if (cfg_chan.valid) begin
      op_mode_r <= cfg_chan.op_mode;
    end
  end

  always_comb begin
    push_cmd.value     = in_chan.value;
    push_cmd.fin_union = (op_mode_r == MODE_UNION);
    unique case (op_mode_r)
      MODE_UNION: begin push_cmd.want_hit = 1'b1; push_cmd.want_miss = 1'b1; end
      MODE_INTER: begin push_cmd.want_hit = 1'b1; push_cmd.want_miss = 1'b0; end
      MODE_DIFF:  begin push_cmd.want_hit = 1'b0; push_cmd.want_miss = 1'b1; end
      default:    begin push_cmd.want_hit = 1'b0; push_cmd.want_miss = 1'b0; end
    endcase
    // Requests that can never change state or give a result are dropped here:
    // the unused kind code, and probes under the unused mode code.
    unique case (in_chan.kind)
      KIND_LOAD:   begin push_cmd.op = OP_LOAD;   keep = 1'b1; end
      KIND_PROBE:  begin
        push_cmd.op = OP_PROBE;
        keep        = push_cmd.want_hit | push_cmd.want_miss;
      end
      KIND_FINISH: begin push_cmd.op = OP_FINISH; keep = 1'b1; end
      default:     begin push_cmd.op = OP_LOAD;   keep = 1'b0; end
    endcase
  end

  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid & keep;

endmodule

`default_nettype wire

### design/sui_queue.sv
// Two-entry command queue between the front end and the engine.
// Depends on sui_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sui_queue import sui_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire cmd_t   push_cmd,
  output logic        pop_valid,
  input  wire logic   pop,
  output cmd_t        pop_cmd
);

  localparam int QD  = 2;
  localparam int QPW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  cmd_t           ent_r [QD];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != QCW'(QD));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = ent_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == QPW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == QPW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/sui_back.sv
// Engine: reference and emitted stores, sequential scans and the result register.
// Depends on sui_pkg and sui_if.
`timescale 1ns / 1ps
`default_nettype none

module sui_back import sui_pkg::*; #(
  parameter int REF_DEPTH = 32,
  parameter int OUT_DEPTH = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire cmd_t   q_cmd,
  output logic        q_pop,
  sui_out_if.source   out_chan
);

  localparam int RAW  = $clog2(REF_DEPTH);
  localparam int EAW  = $clog2(OUT_DEPTH);
  localparam int RCW  = $clog2(REF_DEPTH + 1);
  localparam int ECW  = $clog2(OUT_DEPTH + 1);
  localparam int MAXD = (REF_DEPTH > OUT_DEPTH) ? REF_DEPTH : OUT_DEPTH;
  localparam int SW   = $clog2(MAXD + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FIN_RD,
    ST_FIN_GOT,
    ST_FIN_END
  } state_t;

  // Stores
  logic [VAL_W-1:0] ref_mem [REF_DEPTH];
  logic [VAL_W-1:0] em_mem  [OUT_DEPTH];
  logic [VAL_W-1:0] ref_q_r;
  logic [VAL_W-1:0] em_q_r;
  logic             ref_we, ref_re, em_we, em_re;
  logic [RAW-1:0]   ref_ra;
  logic [EAW-1:0]   em_ra;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    k_r, k_nxt;
  logic [RCW-1:0]   ref_cnt_r, ref_cnt_nxt;
  logic [ECW-1:0]   em_cnt_r, em_cnt_nxt;
  logic [REF_DEPTH-1:0] done_r, done_nxt;  // reference entry already emitted
  logic             ovf_r, ovf_nxt;
  logic             ref_hit_r, ref_hit_nxt;
  logic             em_hit_r, em_hit_nxt;
  logic [RAW-1:0]   hit_idx_r, hit_idx_nxt;
  logic             ref_rv_r, ref_rv_nxt;
  logic             em_rv_r, em_rv_nxt;
  logic [RAW-1:0]   ref_ridx_r, ref_ridx_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [VAL_W-1:0] pend_r, pend_nxt;
  logic             out_v_r, out_v_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  logic             out_has_r, out_has_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             out_free;
  logic             ref_more, em_more, want;

  always_ff @(posedge clk) begin
    if (ref_we) ref_mem[ref_cnt_r[RAW-1:0]] <= q_cmd.value;
    if (ref_re) ref_q_r <= ref_mem[ref_ra];
  end

  always_ff @(posedge clk) begin
    if (em_we) em_mem[em_cnt_r[EAW-1:0]] <= q_cmd.value;
    if (em_re) em_q_r <= em_mem[em_ra];
  end

  assign ref_ra   = k_r[RAW-1:0];
  assign em_ra    = k_r[EAW-1:0];
  assign out_free = ~out_v_r | out_chan.ready;
  assign ref_more = (k_r < SW'(ref_cnt_r));
  assign em_more  = (k_r < SW'(em_cnt_r));
  assign want     = ref_hit_r ? q_cmd.want_hit : q_cmd.want_miss;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    ref_cnt_nxt  = ref_cnt_r;
    em_cnt_nxt   = em_cnt_r;
    done_nxt     = done_r;
    ovf_nxt      = ovf_r;
    ref_hit_nxt  = ref_hit_r;
    em_hit_nxt   = em_hit_r;
    hit_idx_nxt  = hit_idx_r;
    ref_rv_nxt   = 1'b0;
    em_rv_nxt    = 1'b0;
    ref_ridx_nxt = k_r[RAW-1:0];
    n_nxt        = n_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r & ~out_chan.ready;
    out_val_nxt  = out_val_r;
    out_has_nxt  = out_has_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    ref_we       = 1'b0;
    ref_re       = 1'b0;
    em_we        = 1'b0;
    em_re        = 1'b0;
    q_pop        = 1'b0;

    // Compare stage of the scan: data read in the previous cycle.
    if (ref_rv_r && ref_q_r == q_cmd.value) begin
      ref_hit_nxt = 1'b1;
      hit_idx_nxt = ref_ridx_r;
    end
    if (em_rv_r && em_q_r == q_cmd.value) begin
      em_hit_nxt = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          k_nxt       = '0;
          ref_hit_nxt = 1'b0;
          em_hit_nxt  = 1'b0;
          n_nxt       = '0;
          pend_v_nxt  = 1'b0;
          unique case (q_cmd.op)
            OP_FINISH: state_nxt = q_cmd.fin_union ? ST_FIN_RD : ST_FIN_END;
            default:   state_nxt = ST_SCAN;
          endcase
        end
      end

      // Walk both stores together, one entry each per cycle.
      ST_SCAN: begin
        ref_re     = ref_more;
        ref_rv_nxt = ref_more;
        em_re      = em_more;
        em_rv_nxt  = em_more;
        if (ref_more || em_more) begin
          k_nxt = k_r + 1'b1;
        end else if (!ref_rv_r && !em_rv_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        unique case (q_cmd.op)
          OP_LOAD: begin
            if (!ref_hit_r) begin
              if (ref_cnt_r < RCW'(REF_DEPTH)) begin
                ref_we = 1'b1;
                done_nxt[ref_cnt_r[RAW-1:0]] = em_hit_r;
                ref_cnt_nxt = ref_cnt_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            q_pop     = 1'b1;
            state_nxt = ST_IDLE;
          end
          OP_PROBE: begin
            if (!want || em_hit_r) begin
              q_pop     = 1'b1;
              state_nxt = ST_IDLE;
            end else if (em_cnt_r == ECW'(OUT_DEPTH)) begin
              ovf_nxt   = 1'b1;
              q_pop     = 1'b1;
              state_nxt = ST_IDLE;
            end else if (out_free) begin
              em_we        = 1'b1;
              em_cnt_nxt   = em_cnt_r + 1'b1;
              if (ref_hit_r) done_nxt[hit_idx_r] = 1'b1;
              out_v_nxt    = 1'b1;
              out_val_nxt  = q_cmd.value;
              out_has_nxt  = 1'b1;
              out_last_nxt = 1'b0;
              out_ovf_nxt  = ovf_r;
              q_pop        = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
          default: begin
            q_pop     = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end

      // Union finish: find the next reference entry not yet emitted.
      ST_FIN_RD: begin
        if (!ref_more || n_r == N_W'(MAX_RESULTS)) begin
          state_nxt = ST_FIN_END;
        end else if (done_r[k_r[RAW-1:0]]) begin
          k_nxt = k_r + 1'b1;
        end else begin
          ref_re    = 1'b1;
          state_nxt = ST_FIN_GOT;
        end
      end

      // One value is held back so that the final one can carry last.
      ST_FIN_GOT: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_v_nxt    = 1'b1;
            out_val_nxt  = pend_r;
            out_has_nxt  = 1'b1;
            out_last_nxt = 1'b0;
            out_ovf_nxt  = ovf_r;
          end
          pend_nxt   = ref_q_r;
          pend_v_nxt = 1'b1;
          n_nxt      = n_r + 1'b1;
          k_nxt      = k_r + 1'b1;
          state_nxt  = ST_FIN_RD;
        end
      end

      ST_FIN_END: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_val_nxt  = pend_v_r ? pend_r : '0;
          out_has_nxt  = pend_v_r;
          out_last_nxt = 1'b1;
          out_ovf_nxt  = ovf_r;
          ref_cnt_nxt  = '0;
          em_cnt_nxt   = '0;
          done_nxt     = '0;
          pend_v_nxt   = 1'b0;
          q_pop        = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ref_cnt_r <= '0;
      em_cnt_r  <= '0;
      done_r    <= '0;
      ovf_r     <= 1'b0;
      ref_rv_r  <= 1'b0;
      em_rv_r   <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ref_cnt_r <= ref_cnt_nxt;
      em_cnt_r  <= em_cnt_nxt;
      done_r    <= done_nxt;
      ovf_r     <= ovf_nxt;
      ref_rv_r  <= ref_rv_nxt;
      em_rv_r   <= em_rv_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
    k_r        <= k_nxt;
    ref_hit_r  <= ref_hit_nxt;
    em_hit_r   <= em_hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    ref_ridx_r <= ref_ridx_nxt;
    n_r        <= n_nxt;
    pend_r     <= pend_nxt;
    out_val_r  <= out_val_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.result_value  = out_val_r;
  assign out_chan.has_value     = out_has_r;
  assign out_chan.last          = out_last_r;
  assign out_chan.overflow_seen = out_ovf_r;

endmodule

`default_nettype wire

### design/set_union_intersect_difference_core.sv
// Set union/intersection/difference core. Load or probe: a dispatch step, a scan of both
// stores together, then a decide step (a probe result waits there for a free result register).
// Finish: a dispatch step; in union mode a walk of the reference store that skips entries
// already emitted and reads and flushes each other value, then the last result. One request
// is in the engine at a time; the queue and the result register decouple.
// Reset (rst_n, sync, active low) clears mode, counts, flags, handshakes; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module set_union_intersect_difference_core import sui_pkg::*; #(
  parameter int REF_DEPTH = 32,
  parameter int OUT_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sui_in_if.sink     in_chan,
  sui_out_if.source  out_chan,
  sui_cfg_if.sink    cfg_chan
);

  // Front end to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // Queue to engine
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Front end: op_mode register plus request classification. Requests that cannot
  // produce anything (unused kind, probes under the unused mode) die here.
  sui_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decoupling queue: the front keeps taking requests while the engine scans, until the queue is full.
  sui_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // Engine: stores, duplicate checks by sequential scan, union flush on finish,
  // and the registered result stage.
  sui_back #(
    .REF_DEPTH (REF_DEPTH),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
